@@ sv/prr_pkg.sv @@
// prr_pkg: types and constants shared by the polyphase resampler modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

  // store sizes, tied to the register and index widths below
  localparam int MAX_PHASES  = 16;
  localparam int MAX_TAPS    = 64;

  // fixed field widths
  localparam int UP_W        = 5;
  localparam int DOWN_W      = 5;
  localparam int TAPS_W      = 7;
  localparam int PHASE_W     = 6;   // running phase, holds up to up_factor + down_factor
  localparam int PACC_W      = 5;   // phase accumulator between pushes
  localparam int OUT_PHASE_W = 4;
  localparam int COEF_W      = 16;
  localparam int COEF_IDX_W  = 10;
  localparam int FRAC_BITS   = 15;
  localparam int MAX_STEP    = 16;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [1:0] REG_UP   = 2'd0;
  localparam logic [1:0] REG_DOWN = 2'd1;
  localparam logic [1:0] REG_TAPS = 2'd2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_COEF = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [UP_W-1:0]   up;
    logic [DOWN_W-1:0] down;
    logic [TAPS_W-1:0] taps;
  } cfg_t;

  typedef struct packed {
    logic coef_wr;    // store one coefficient
    logic push;       // write sample into history
    logic out_start;  // begin a new output sum
    logic tap_issue;  // read one tap and advance addresses
    logic out_load;   // round the sum into the output register
    logic last;       // final output of this push
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/prr_in_if.sv @@
// prr_in_if: input channel of the resampler, commands and samples
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface prr_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [9:0]                     coef_index;
  logic signed [15:0]             coef_value;

  modport source (
    output valid, command, sample_i, sample_q, coef_index, coef_value,
    input  ready
  );

  modport sink (
    input  valid, command, sample_i, sample_q, coef_index, coef_value,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/prr_out_if.sv @@
// prr_out_if: output channel of the resampler, resampled complex samples
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface prr_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_i;
  logic signed [SAMPLE_WIDTH-1:0] out_q;
  logic [3:0]                     out_phase;
  logic                           last;

  modport source (
    output valid, out_i, out_q, out_phase, last,
    input  ready
  );

  modport sink (
    input  valid, out_i, out_q, out_phase, last,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/polyphase_rational_resampler_top.sv @@
// Polyphase rational resampler for complex samples, ratio up_factor/down_factor.
// A coefficient write (command 1) is taken without leaving the idle state. A
// sample push (command 0) walks the phase accumulator; every output it causes
// runs one shared complex MAC (two 16-bit real-by-sample multipliers) over
// taps_per_phase taps, one tap per cycle, then lets the MAC pipeline drain and
// waits for the output register to be free, so the next transaction is taken
// only once every output of the push is loaded, or once a push that gives no
// output leaves the start state. The tap loop through the single MAC sets this
// pace. The sample history is cleared at reset by per-entry valid bits, so no
// clearing pass is needed. Registers sit at byte addresses 0, 4 and 8.
// depends on prr_pkg, prr_in_if, prr_out_if, prr_regs, prr_ctrl, prr_datapath
`timescale 1ns / 1ps
`default_nettype none

module polyphase_rational_resampler_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  prr_in_if.sink                                in_ch,
  prr_out_if.source                             out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [prr_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [prr_pkg::APB_DATA_W-1:0]   pwdata,
  output      logic [prr_pkg::APB_DATA_W-1:0]   prdata,
  output      logic                             pready
);

  prr_pkg::cfg_t               cfg;
  prr_pkg::cmd_t               cmd;
  prr_pkg::stat_t              status;
  logic [prr_pkg::PHASE_W-1:0] phase;
  logic [prr_pkg::UP_W-1:0]    step;

  prr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .cfg        (cfg),
    .status     (status),
    .cmd        (cmd),
    .phase      (phase),
    .step       (step)
  );

  prr_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .phase      (phase),
    .step       (step),
    .sample_i   (in_ch.sample_i),
    .sample_q   (in_ch.sample_q),
    .coef_index (in_ch.coef_index),
    .coef_value (in_ch.coef_value),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_i      (out_ch.out_i),
    .out_q      (out_ch.out_q),
    .out_phase  (out_ch.out_phase),
    .out_last   (out_ch.last)
  );

endmodule

`default_nettype wire

@@ sv/prr_regs.sv @@
// prr_regs: apb register file holding up_factor, down_factor, taps_per_phase
// depends on prr_pkg
`timescale 1ns / 1ps
`default_nettype none

module prr_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [prr_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [prr_pkg::APB_DATA_W-1:0]   pwdata,
  output      logic [prr_pkg::APB_DATA_W-1:0]   prdata,
  output      logic                             pready,
  output      prr_pkg::cfg_t                    cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up   <= prr_pkg::UP_W'(1);
      cfg.down <= prr_pkg::DOWN_W'(1);
      cfg.taps <= prr_pkg::TAPS_W'(16);
    end else if (wr_en) begin
      case (paddr[3:2])
        prr_pkg::REG_UP:   cfg.up   <= pwdata[prr_pkg::UP_W-1:0];
        prr_pkg::REG_DOWN: cfg.down <= pwdata[prr_pkg::DOWN_W-1:0];
        prr_pkg::REG_TAPS: cfg.taps <= pwdata[prr_pkg::TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      prr_pkg::REG_UP:   prdata = prr_pkg::APB_DATA_W'(cfg.up);
      prr_pkg::REG_DOWN: prdata = prr_pkg::APB_DATA_W'(cfg.down);
      prr_pkg::REG_TAPS: prdata = prr_pkg::APB_DATA_W'(cfg.taps);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/prr_ctrl.sv @@
// prr_ctrl: sequencer for the resampler, walks phases and taps of each push
// depends on prr_pkg; drives prr_datapath through cmd_t and reads stat_t
`timescale 1ns / 1ps
`default_nettype none

module prr_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_command,
  output      logic                          in_ready,
  input  wire prr_pkg::cfg_t                 cfg,
  input  wire prr_pkg::stat_t                status,
  output      prr_pkg::cmd_t                 cmd,
  output      logic [prr_pkg::PHASE_W-1:0]   phase,
  output      logic [prr_pkg::UP_W-1:0]      step
);

  prr_pkg::state_t state, state_next;

  logic [prr_pkg::PHASE_W-1:0] r, r_next;
  logic [prr_pkg::PACC_W-1:0]  pacc, pacc_next;
  logic [prr_pkg::TAPS_W-1:0]  j, j_next;

  logic [prr_pkg::UP_W-1:0]    up_c;
  logic [prr_pkg::DOWN_W-1:0]  down_c;
  logic [prr_pkg::TAPS_W-1:0]  taps_c;
  logic [prr_pkg::PHASE_W-1:0] r_step;
  logic [prr_pkg::PHASE_W-1:0] up_ext;
  logic                        accept;

  // registers saturated to their legal ranges
  always_comb begin
    if (cfg.up == '0)
      up_c = prr_pkg::UP_W'(1);
    else if (32'(cfg.up) > prr_pkg::MAX_PHASES)
      up_c = prr_pkg::UP_W'(prr_pkg::MAX_PHASES);
    else
      up_c = cfg.up;

    if (cfg.down == '0)
      down_c = prr_pkg::DOWN_W'(1);
    else if (32'(cfg.down) > prr_pkg::MAX_STEP)
      down_c = prr_pkg::DOWN_W'(prr_pkg::MAX_STEP);
    else
      down_c = cfg.down;

    if (cfg.taps == '0)
      taps_c = prr_pkg::TAPS_W'(1);
    else if (32'(cfg.taps) > prr_pkg::MAX_TAPS)
      taps_c = prr_pkg::TAPS_W'(prr_pkg::MAX_TAPS);
    else
      taps_c = cfg.taps;
  end

  assign up_ext = prr_pkg::PHASE_W'(up_c);
  assign r_step = r + prr_pkg::PHASE_W'(down_c);
  assign phase  = r;
  assign step   = up_c;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prr_pkg::S_IDLE;
      r     <= '0;
      pacc  <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
      pacc  <= pacc_next;
      j     <= j_next;
    end
  end

  always_comb begin
    state_next = state;
    r_next     = r;
    pacc_next  = pacc;
    j_next     = j;
    cmd        = '0;
    in_ready   = 1'b0;

    case (state)
      prr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_command == prr_pkg::CMD_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.push   = 1'b1;
            r_next     = prr_pkg::PHASE_W'(pacc);
            state_next = prr_pkg::S_START;
          end
        end
      end

      prr_pkg::S_START: begin
        if (r < up_ext) begin
          cmd.out_start = 1'b1;
          j_next        = '0;
          state_next    = prr_pkg::S_MAC;
        end else begin
          // phase already past the branch count: no output for this push
          pacc_next  = prr_pkg::PACC_W'(r - up_ext);
          state_next = prr_pkg::S_IDLE;
        end
      end

      prr_pkg::S_MAC: begin
        cmd.tap_issue = 1'b1;
        j_next        = j + 1'b1;
        if (j == taps_c - 1'b1)
          state_next = prr_pkg::S_DRAIN;
      end

      prr_pkg::S_DRAIN: begin
        if (!status.pipe_busy)
          state_next = prr_pkg::S_EMIT;
      end

      prr_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.last     = (r_step >= up_ext);
          r_next       = r_step;
          if (r_step >= up_ext) begin
            pacc_next  = prr_pkg::PACC_W'(r_step - up_ext);
            state_next = prr_pkg::S_IDLE;
          end else begin
            state_next = prr_pkg::S_START;
          end
        end
      end

      default: state_next = prr_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_push_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_command == prr_pkg::CMD_PUSH) |=> state == prr_pkg::S_START)
    else $error("push did not start phase walk");

  a_load_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.pipe_busy)
    else $error("output loaded while mac pipeline busy");

  a_pacc_range: assert property (@(posedge clk) disable iff (rst)
    state == prr_pkg::S_IDLE |-> 32'(pacc) < prr_pkg::MAX_STEP)
    else $error("phase accumulator out of range");

  a_mac_in_range: assert property (@(posedge clk) disable iff (rst)
    state == prr_pkg::S_MAC |-> r < up_ext)
    else $error("mac running on a phase beyond up_factor");
`endif

endmodule

`default_nettype wire

@@ sv/prr_datapath.sv @@
// prr_datapath: coefficient store, sample history, complex mac and output register
// depends on prr_pkg; commanded by prr_ctrl
`timescale 1ns / 1ps
`default_nettype none

module prr_datapath #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire prr_pkg::cmd_t                           cmd,
  output      prr_pkg::stat_t                          status,
  input  wire logic [prr_pkg::PHASE_W-1:0]             phase,
  input  wire logic [prr_pkg::UP_W-1:0]                step,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          sample_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          sample_q,
  input  wire logic [prr_pkg::COEF_IDX_W-1:0]          coef_index,
  input  wire logic signed [prr_pkg::COEF_W-1:0]       coef_value,
  output      logic                                    out_valid,
  input  wire logic                                    out_ready,
  output      logic signed [SAMPLE_WIDTH-1:0]          out_i,
  output      logic signed [SAMPLE_WIDTH-1:0]          out_q,
  output      logic [prr_pkg::OUT_PHASE_W-1:0]         out_phase,
  output      logic                                    out_last
);

  localparam int COEF_DEPTH = prr_pkg::MAX_PHASES * prr_pkg::MAX_TAPS;
  localparam int CI_W       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int HP_W       = $clog2(prr_pkg::MAX_TAPS);
  localparam int PROD_W     = SAMPLE_WIDTH + prr_pkg::COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(prr_pkg::MAX_TAPS);
  localparam int SH_W       = ACC_W + 1 - prr_pkg::FRAC_BITS;

  logic signed [prr_pkg::COEF_W-1:0]  coef_mem [COEF_DEPTH];
  logic [2*SAMPLE_WIDTH-1:0]          hist_mem [prr_pkg::MAX_TAPS];
  logic [prr_pkg::MAX_TAPS-1:0]       hist_vld;

  logic [HP_W-1:0] wp, base, hp;
  logic [CI_W-1:0] ci;

  // stage 1: memory read data
  logic                              s1_vld;
  logic signed [prr_pkg::COEF_W-1:0] coef_rd;
  logic [2*SAMPLE_WIDTH-1:0]         hist_rd;
  logic                              hv_rd;
  logic signed [SAMPLE_WIDTH-1:0]    smp_i, smp_q;

  // stage 2: products
  logic                     s2_vld;
  logic signed [PROD_W-1:0] prod_i, prod_q;

  // stage 3: sums
  logic signed [ACC_W-1:0] acc_i, acc_q;

  function automatic logic [HP_W-1:0] ptr_dec(input logic [HP_W-1:0] p);
    logic [HP_W-1:0] res;
    if (p == '0)
      res = HP_W'(prr_pkg::MAX_TAPS - 1);
    else
      res = p - 1'b1;
    return res;
  endfunction

  function automatic logic [HP_W-1:0] ptr_inc(input logic [HP_W-1:0] p);
    logic [HP_W-1:0] res;
    if (32'(p) == prr_pkg::MAX_TAPS - 1)
      res = '0;
    else
      res = p + 1'b1;
    return res;
  endfunction

  // round half up from q15 and saturate to the sample width
  function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic [ACC_W:0]   v;
    logic [SH_W-1:0]  s;
    logic [SAMPLE_WIDTH-1:0] res;
    v = {a[ACC_W-1], a} + (ACC_W+1)'(1 << (prr_pkg::FRAC_BITS - 1));
    s = v[ACC_W:prr_pkg::FRAC_BITS];
    if ((&s[SH_W-1:SAMPLE_WIDTH-1]) || !(|s[SH_W-1:SAMPLE_WIDTH-1]))
      res = s[SAMPLE_WIDTH-1:0];
    else if (s[SH_W-1])
      res = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    else
      res = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    return res;
  endfunction

  // coefficient store
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (32'(coef_index) < COEF_DEPTH))
      coef_mem[CI_W'(coef_index)] <= coef_value;
    if (cmd.tap_issue)
      coef_rd <= coef_mem[ci];
  end

  // sample history
  always_ff @(posedge clk) begin
    if (cmd.push)
      hist_mem[wp] <= {sample_i, sample_q};
    if (cmd.tap_issue)
      hist_rd <= hist_mem[hp];
  end

  // entries never pushed since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      wp       <= '0;
    end else if (cmd.push) begin
      hist_vld[wp] <= 1'b1;
      wp           <= ptr_inc(wp);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push)
      base <= wp;
    if (cmd.tap_issue)
      hv_rd <= hist_vld[hp];
    if (cmd.out_start) begin
      hp <= base;
      ci <= CI_W'(phase);
    end else if (cmd.tap_issue) begin
      hp <= ptr_dec(hp);
      ci <= ci + CI_W'(step);
    end
  end

  assign smp_i = hv_rd ? $signed(hist_rd[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]) : '0;
  assign smp_q = hv_rd ? $signed(hist_rd[SAMPLE_WIDTH-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.tap_issue;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      prod_i <= coef_rd * smp_i;
      prod_q <= coef_rd * smp_q;
    end
    if (cmd.out_start) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (s2_vld) begin
      acc_i <= acc_i + {{(ACC_W-PROD_W){prod_i[PROD_W-1]}}, prod_i};
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (cmd.out_load)
      out_valid <= 1'b1;
    else if (out_ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_i     <= round_sat(acc_i);
      out_q     <= round_sat(acc_q);
      out_phase <= phase[prr_pkg::OUT_PHASE_W-1:0];
      out_last  <= cmd.last;
    end
  end

  assign status.pipe_busy = s1_vld || s2_vld;
  assign status.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking bench for the polyphase rational resampler, with a built-in predictor
// depends on prr_pkg, prr_in_if, prr_out_if and polyphase_rational_resampler_top
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PHASES    = prr_pkg::MAX_PHASES;
  localparam int MAX_TAPS      = prr_pkg::MAX_TAPS;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int COEF_DEPTH    = MAX_PHASES * MAX_TAPS;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int NUM_PHASES    = 8;
  localparam int NUM_ROWS      = 26;
  // coefficients written up front; every configuration keeps its taps below this
  localparam int FILL_DEPTH    = 64;

  // register slot with nothing behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    ROW_PUSH,
    ROW_COEF,
    ROW_REG
  } row_kind_t;

  // arg_a: sample_i, coefficient index or register index
  // arg_b: sample_q, coefficient value or register value
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] arg_a;
    logic [15:0] arg_b;
    logic        typed;
    logic [15:0] typed_i;
    logic [15:0] typed_q;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic [3:0]         phase;
    logic               last;
  } resampled_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // reset config: up 1, down 1, taps 16, history all zero
    '{ROW_COEF, 16'd0,          16'h8000,     1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'h7fff,       16'h8000,     1'b1, 16'h8001, 16'h7fff},
    '{ROW_REG,  16'(prr_pkg::REG_TAPS), 16'd0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'h0001,       16'hffff,     1'b1, 16'hffff, 16'h0001},
    '{ROW_PUSH, 16'h0000,       16'h0000,     1'b1, 16'h0000, 16'h0000},
    // half-scale tap, rounding goes half up
    '{ROW_COEF, 16'd0,          16'h4000,     1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'h0001,       16'hffff,     1'b1, 16'h0001, 16'h0000},
    '{ROW_PUSH, 16'h0003,       16'hfffd,     1'b1, 16'h0002, 16'hffff},
    '{ROW_COEF, 16'd0,          16'h7fff,     1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'h8000,       16'h7fff,     1'b1, 16'h8001, 16'h7ffe},
    '{ROW_COEF, 16'd1023,       16'h8000,     1'b0, 16'h0000, 16'h0000},
    // out-of-range registers, widest filter
    '{ROW_REG,  16'(prr_pkg::REG_TAPS), 16'd127, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG,  16'(prr_pkg::REG_DOWN), 16'd0,   1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'h8000,       16'h7fff,     1'b0, 16'h0000, 16'h0000},
    // leave the accumulator at 2, then shrink up_factor below it
    '{ROW_REG,  16'(prr_pkg::REG_UP),   16'd3,   1'b0, 16'h0000, 16'h0000},
    '{ROW_REG,  16'(prr_pkg::REG_DOWN), 16'd5,   1'b0, 16'h0000, 16'h0000},
    '{ROW_REG,  16'(prr_pkg::REG_TAPS), 16'd4,   1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'd12345,      -16'sd12345,  1'b0, 16'h0000, 16'h0000},
    '{ROW_REG,  16'(prr_pkg::REG_UP),   16'd1,   1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'd100,        -16'sd100,    1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, -16'sd200,      16'd200,      1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'd300,        -16'sd300,    1'b0, 16'h0000, 16'h0000},
    '{ROW_REG,  16'(REG_SPARE), 16'd5,        1'b0, 16'h0000, 16'h0000},
    '{ROW_REG,  16'(prr_pkg::REG_DOWN), 16'd31,  1'b0, 16'h0000, 16'h0000},
    '{ROW_REG,  16'(prr_pkg::REG_UP),   16'd31,  1'b0, 16'h0000, 16'h0000},
    '{ROW_PUSH, 16'h7fff,       16'h7fff,     1'b0, 16'h0000, 16'h0000}
  };

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [prr_pkg::APB_ADDR_W-1:0]   paddr;
  logic [prr_pkg::APB_DATA_W-1:0]   pwdata;
  logic [prr_pkg::APB_DATA_W-1:0]   prdata;
  logic                             pready;

  prr_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) in_ch ();
  prr_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_ch ();

  polyphase_rational_resampler_top #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [prr_pkg::UP_W-1:0]   cfg_up   = 5'd1;
  logic [prr_pkg::DOWN_W-1:0] cfg_down = 5'd1;
  logic [prr_pkg::TAPS_W-1:0] cfg_taps = 7'd16;
  logic signed [15:0] hist_i [MAX_TAPS];
  logic signed [15:0] hist_q [MAX_TAPS];
  logic signed [15:0] coef_mem [COEF_DEPTH];
  int                 wr_ptr    = 0;
  int                 phase_acc = 0;

  resampled_t expected_outs [$];
  resampled_t head_out;
  int         mismatches   = 0;
  int         cycle_count  = 0;
  int         in_idle_pct  = 0;
  int         out_idle_pct = 0;
  int         out_stall    = 0;

  function automatic logic signed [15:0] round_to_q15(longint sum);
    longint scaled;
    scaled = (sum + 64'sd16384) >>> prr_pkg::FRAC_BITS;
    if (scaled > 32767) return 16'sh7fff;
    if (scaled < -32768) return 16'sh8000;
    return scaled[15:0];
  endfunction

  // advance the resampler by one input transaction, appending the outputs it causes
  function automatic void resample_item(logic cmd, logic signed [15:0] si,
                                        logic signed [15:0] sq, logic [9:0] idx,
                                        logic signed [15:0] val, ref resampled_t outs[$]);
    int         up;
    int         down;
    int         taps;
    int         r;
    int         hp;
    longint     sum_i;
    longint     sum_q;
    resampled_t res;
    if (cmd == prr_pkg::CMD_COEF) begin
      coef_mem[idx] = val;
      return;
    end
    up   = (cfg_up == 0) ? 1 : (cfg_up > MAX_PHASES) ? MAX_PHASES : int'(cfg_up);
    down = (cfg_down == 0) ? 1 :
           (cfg_down > prr_pkg::MAX_STEP) ? prr_pkg::MAX_STEP : int'(cfg_down);
    taps = (cfg_taps == 0) ? 1 : (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
    hist_i[wr_ptr] = si;
    hist_q[wr_ptr] = sq;
    r = phase_acc;
    while (r < up) begin
      sum_i = 0;
      sum_q = 0;
      for (int j = 0; j < taps; j++) begin
        hp = (wr_ptr + MAX_TAPS - j) % MAX_TAPS;
        sum_i += longint'(coef_mem[j * up + r]) * longint'(hist_i[hp]);
        sum_q += longint'(coef_mem[j * up + r]) * longint'(hist_q[hp]);
      end
      res.out_i = round_to_q15(sum_i);
      res.out_q = round_to_q15(sum_q);
      res.phase = r[3:0];
      res.last  = 1'b0;
      outs.push_back(res);
      r += down;
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    // accumulator past up_factor after a register change: no output, still wraps
    phase_acc = (r >= up) ? r - up : 0;
    wr_ptr    = (wr_ptr + 1) % MAX_TAPS;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'sh8000;
      2: return 16'sh7fff;
      default: return 16'($urandom_range(0, 8191)) - 16'sd4096;
    endcase
  endfunction

  task automatic send_item(logic cmd, logic signed [15:0] si, logic signed [15:0] sq,
                           logic [9:0] idx, logic signed [15:0] val, bit typed = 1'b0,
                           logic [15:0] typed_i = '0, logic [15:0] typed_q = '0);
    resampled_t outs [$];
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.sample_i   <= si;
    in_ch.sample_q   <= sq;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    resample_item(cmd, si, sq, idx, val, outs);
    if (typed) begin
      outs[0].out_i = typed_i;
      outs[0].out_q = typed_q;
    end
    foreach (outs[k]) expected_outs.push_back(outs[k]);
  endtask

  // registers change only with nothing in flight
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [prr_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= prr_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      prr_pkg::REG_UP:   cfg_up   = data[prr_pkg::UP_W-1:0];
      prr_pkg::REG_DOWN: cfg_down = data[prr_pkg::DOWN_W-1:0];
      prr_pkg::REG_TAPS: cfg_taps = data[prr_pkg::TAPS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall    <= out_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
      out_stall    <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_outs.size() == 0) begin
        $error("unexpected output transaction: out_i %0d out_q %0d out_phase %0d",
               out_ch.out_i, out_ch.out_q, out_ch.out_phase);
        mismatches++;
      end else begin
        head_out = expected_outs.pop_front();
        if (out_ch.out_i !== head_out.out_i) begin
          $error("out_i: expected %0d, got %0d", head_out.out_i, out_ch.out_i);
          mismatches++;
        end
        if (out_ch.out_q !== head_out.out_q) begin
          $error("out_q: expected %0d, got %0d", head_out.out_q, out_ch.out_q);
          mismatches++;
        end
        if (out_ch.out_phase !== head_out.phase) begin
          $error("out_phase: expected %0d, got %0d", head_out.phase, out_ch.out_phase);
          mismatches++;
        end
        if (out_ch.last !== head_out.last) begin
          $error("last: expected %0d, got %0d", head_out.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t                      row;
    logic [prr_pkg::APB_DATA_W-1:0] up_raw;
    logic [prr_pkg::APB_DATA_W-1:0] down_raw;
    logic [prr_pkg::APB_DATA_W-1:0] taps_raw;
    int                             n_items;
    int                             up_eff;
    int                             taps_max;

    for (int k = 0; k < MAX_TAPS; k++) begin
      hist_i[k] = '0;
      hist_q[k] = '0;
    end
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.command    = prr_pkg::CMD_PUSH;
    in_ch.sample_i   = '0;
    in_ch.sample_q   = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    in_idle_pct  = 20;
    out_idle_pct = 20;

    // fill every tap that the configurations below can reach
    for (int k = 0; k < FILL_DEPTH; k++)
      send_item(prr_pkg::CMD_COEF, rand_sample(), rand_sample(), 10'(k), rand_coef());

    foreach (DIRECTED_ROWS[n]) begin
      row = DIRECTED_ROWS[n];
      case (row.kind)
        ROW_REG: begin
          wait_idle();
          write_reg(row.arg_a[1:0], prr_pkg::APB_DATA_W'(row.arg_b));
        end
        ROW_COEF: begin
          send_item(prr_pkg::CMD_COEF, rand_sample(), rand_sample(), row.arg_a[9:0],
                    row.arg_b);
        end
        default: begin
          send_item(prr_pkg::CMD_PUSH, row.arg_a, row.arg_b, 10'($urandom), rand_coef(),
                    row.typed, row.typed_i, row.typed_q);
        end
      endcase
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          up_raw   = 31;
          down_raw = 1;
          taps_raw = 4;
          n_items  = 4;
        end
        1: begin
          up_raw   = 1;
          down_raw = 16;
          taps_raw = 1;
          n_items  = 24;
        end
        default: begin
          case ($urandom_range(0, 7))
            0: up_raw = 0;
            1: up_raw = $urandom_range(17, 31);
            default: up_raw = $urandom_range(1, 16);
          endcase
          case ($urandom_range(0, 7))
            0: down_raw = 0;
            1: down_raw = $urandom_range(17, 31);
            default: down_raw = $urandom_range(1, 16);
          endcase
          up_eff   = (up_raw == 0) ? 1 : (up_raw > MAX_PHASES) ? MAX_PHASES : int'(up_raw);
          taps_max = FILL_DEPTH / up_eff;
          case ($urandom_range(0, 7))
            0: taps_raw = 0;
            1: taps_raw = (taps_max == MAX_TAPS) ? $urandom_range(65, 127) : taps_max;
            default: taps_raw = $urandom_range(1, taps_max);
          endcase
          n_items = 8;
        end
      endcase
      write_reg(prr_pkg::REG_UP, up_raw);
      write_reg(prr_pkg::REG_DOWN, down_raw);
      write_reg(prr_pkg::REG_TAPS, taps_raw);

      // no idling at all in the closing phase
      if (p == NUM_PHASES - 1) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end

      repeat (n_items) begin
        if ($urandom_range(0, 99) < 15)
          send_item(prr_pkg::CMD_COEF, rand_sample(), rand_sample(),
                    10'($urandom_range(0, FILL_DEPTH - 1)), rand_coef());
        else
          send_item(prr_pkg::CMD_PUSH, rand_sample(), rand_sample(), 10'($urandom),
                    rand_coef());
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_outs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
